@@ rtl/ps2mt_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types and constants for the PS/2 mouse packet tracker: header bit
// positions, packet phase codes, register map and axis control bundle.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int POS_W  = 14;
    localparam int SIZE_W = 15;
    localparam int BTN_W  = 3;
    localparam int MAG_W  = 9;
    localparam int SUM_W  = 16;

    // Largest position the cursor state holds
    localparam logic [POS_W-1:0] POS_MAX = 14'h3FFF;

    // Overflow adds this to the magnitude
    localparam logic [MAG_W-1:0] OVF_ADD = 9'd255;

    // Header bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    // Packet phase codes
    localparam logic [1:0] PH_HDR = 2'd0;
    localparam logic [1:0] PH_DX  = 2'd1;
    localparam logic [1:0] PH_DY  = 2'd2;

    // Register map (word index taken from paddr[2])
    localparam int          PADDR_W    = 3;
    localparam int          PDATA_W    = 32;
    localparam logic        REG_WIDTH  = 1'b0;
    localparam logic        REG_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 15'd1024;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 15'd768;

    // Per-axis movement controls from the header
    typedef struct packed {
        logic neg;     // sign bit of the movement byte
        logic ovf;     // overflow bit: magnitude gains 255
        logic invert;  // axis runs opposite to the mouse sign
    } t_axis_ctl;

endpackage : ps2mt_pkg

@@ rtl/ps2mt_axis.sv @@
// ----------------------------------------------------------------------------
// ps2mt_axis
// One cursor axis: turns a movement byte and its header bits into a signed
// step, adds it to the current position and clamps to the screen size.
// ----------------------------------------------------------------------------
module ps2mt_axis
    import ps2mt_pkg::*;
(
    input  logic [POS_W-1:0]  i_pos,
    input  logic [BYTE_W-1:0] i_data,
    input  t_axis_ctl         i_ctl,
    input  logic [SIZE_W-1:0] i_size,
    output logic [POS_W-1:0]  o_pos
);

    logic [BYTE_W-1:0] mag_base;
    logic [MAG_W-1:0]  mag;
    logic              add;
    logic [SUM_W-1:0]  sum;
    logic [POS_W-1:0]  lim;

    // Magnitude: two's complement of the byte when negative, plus overflow
    assign mag_base = i_ctl.neg ? BYTE_W'(8'd0 - i_data) : i_data;
    assign mag      = {1'b0, mag_base} + (i_ctl.ovf ? OVF_ADD : MAG_W'(0));

    // Step direction: a clear sign adds, an inverted axis flips that
    assign add = ~(i_ctl.neg ^ i_ctl.invert);
    assign sum = add ? ({2'b00, i_pos} + {7'd0, mag})
                     : ({2'b00, i_pos} - {7'd0, mag});

    // Clamp limit: size minus one, zero size acts as one, capped at POS_MAX
    always_comb begin
        if (i_size == '0) begin
            lim = '0;
        end else if (i_size > {1'b0, POS_MAX} + SIZE_W'(1)) begin
            lim = POS_MAX;
        end else begin
            lim = POS_W'(i_size - SIZE_W'(1));
        end
    end

    // Clamp below at zero and above at the limit
    always_comb begin
        if (sum[SUM_W-1]) begin
            o_pos = '0;
        end else if (sum[SIZE_W-1:0] > {1'b0, lim}) begin
            o_pos = lim;
        end else begin
            o_pos = sum[POS_W-1:0];
        end
    end

endmodule : ps2mt_axis

@@ rtl/ps2_mouse_packet_tracker.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Assembles 3-byte PS/2 mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// A result is in the output register in the cycle after its third byte is accepted.
// Throughput: one byte per cycle; the movement add and clamp sit between the
//   packet state registers (and the incoming Y byte) and the result register.
// A byte that completes a packet waits only while a previous result is held.
// Reset (synchronous, active low): drop-first flag set, header phase, cursor
//   at the origin, no result pending, screen 1024 by 768.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker
    import ps2mt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Byte input
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    // Result output
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [POS_W-1:0]   o_cursor_x,
    output logic [POS_W-1:0]   o_cursor_y,
    output logic [BTN_W-1:0]   o_buttons,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;

    logic              r_skip_first, n_skip_first;
    logic [1:0]        r_phase,      n_phase;
    logic [BYTE_W-1:0] r_header,     n_header;
    logic [BYTE_W-1:0] r_dx,         n_dx;
    logic [POS_W-1:0]  r_pos_x;
    logic [POS_W-1:0]  r_pos_y;
    logic [BTN_W-1:0]  r_buttons;
    logic              r_out_valid,  n_out_valid;

    logic              cfg_wr;
    logic              completes;
    logic              rx_fire;
    logic              res_load;
    t_axis_ctl         ctl_x;
    t_axis_ctl         ctl_y;
    logic [POS_W-1:0]  next_x;
    logic [POS_W-1:0]  next_y;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: r_height <= pwdata[SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = {{(PDATA_W-SIZE_W){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(PDATA_W-SIZE_W){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    // Stall only a completing byte, and only while a result is still held
    assign completes  = !r_skip_first && (r_phase == PH_DY);
    assign o_rx_ready = !completes || !r_out_valid || i_res_ready;
    assign rx_fire    = i_rx_valid && o_rx_ready;
    assign res_load   = rx_fire && completes;

    // Axis controls from the stored header; Y runs opposite to the mouse
    assign ctl_x = '{neg: r_header[HDR_XSIGN], ovf: r_header[HDR_XOVF], invert: 1'b0};
    assign ctl_y = '{neg: r_header[HDR_YSIGN], ovf: r_header[HDR_YOVF], invert: 1'b1};

    ps2mt_axis u_axis_x (
        .i_pos  (r_pos_x),
        .i_data (r_dx),
        .i_ctl  (ctl_x),
        .i_size (r_width),
        .o_pos  (next_x)
    );

    ps2mt_axis u_axis_y (
        .i_pos  (r_pos_y),
        .i_data (i_rx_byte),
        .i_ctl  (ctl_y),
        .i_size (r_height),
        .o_pos  (next_y)
    );

    // Packet sequencer: drop first byte, resync headers on the sync bit
    always_comb begin
        n_skip_first = r_skip_first;
        n_phase      = r_phase;
        n_header     = r_header;
        n_dx         = r_dx;
        if (rx_fire) begin
            if (r_skip_first) begin
                n_skip_first = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_DX: begin
                        n_dx    = i_rx_byte;
                        n_phase = PH_DY;
                    end
                    PH_DY: begin
                        n_phase = PH_HDR;
                    end
                    default: begin
                        n_phase = PH_HDR;
                        if (i_rx_byte[HDR_SYNC]) begin
                            n_header = i_rx_byte;
                            n_phase  = PH_DX;
                        end
                    end
                endcase
            end
        end
    end

    // Result valid: set on a completed packet, clear when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (res_load) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_first <= 1'b1;
            r_phase      <= PH_HDR;
            r_out_valid  <= 1'b0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
        end else begin
            r_skip_first <= n_skip_first;
            r_phase      <= n_phase;
            r_out_valid  <= n_out_valid;
            if (res_load) begin
                r_pos_x <= next_x;
                r_pos_y <= next_y;
            end
        end
    end

    // Packet bytes and button payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= '0;
            r_dx      <= '0;
            r_buttons <= '0;
        end else begin
            r_header <= n_header;
            r_dx     <= n_dx;
            if (res_load) begin
                r_buttons <= {r_header[HDR_RIGHT], r_header[HDR_MIDDLE], r_header[HDR_LEFT]};
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_cursor_x  = r_pos_x;
    assign o_cursor_y  = r_pos_y;
    assign o_buttons   = r_buttons;

    // A completing byte always leaves a result pending
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_load) |=> r_out_valid)
        else $error("completed packet did not raise a result");

    // The movement byte is followed by the Y byte phase
    a_dx_to_dy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_fire && !r_skip_first && r_phase == PH_DX) |=> (r_phase == PH_DY))
        else $error("phase did not advance after X byte");

    // Any accepted byte clears the drop-first flag
    a_skip_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_fire) |=> !r_skip_first)
        else $error("first byte flag still set after a byte");

endmodule : ps2_mouse_packet_tracker

@@ bench/ps2mt_checker.sv @@
// ----------------------------------------------------------------------------
// ps2mt_checker
// Watches the byte, result and register channels of the PS/2 mouse packet
// tracker. Predicts the cursor and button state for every completed packet and
// compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ps2mt_checker
    import ps2mt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Byte channel
    input  logic               i_rx_valid,
    input  logic               i_rx_ready,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    // Result channel
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [POS_W-1:0]   i_cursor_x,
    input  logic [POS_W-1:0]   i_cursor_y,
    input  logic [BTN_W-1:0]   i_buttons,
    // Register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    // Status towards the top
    output int                 o_errors,
    output int                 o_outstanding,
    output int                 o_packets
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [BTN_W-1:0] btn;
    } t_cursor;

    t_cursor cursor_q[$];

    // Shadow of the block's registers and packet state
    logic [SIZE_W-1:0] width_q    = WIDTH_RST;
    logic [SIZE_W-1:0] height_q   = HEIGHT_RST;
    logic              drop_first = 1'b1;
    logic [1:0]        pkt_phase  = PH_HDR;
    logic [BYTE_W-1:0] hdr_q      = '0;
    logic [BYTE_W-1:0] dx_q       = '0;
    logic [POS_W-1:0]  cur_x      = '0;
    logic [POS_W-1:0]  cur_y      = '0;

    int err_count     = 0;
    int packet_count  = 0;
    int pending_count = 0;

    assign o_errors      = err_count;
    assign o_outstanding = pending_count;
    assign o_packets     = packet_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        err_count++;
    endtask

    // Signed movement: two's complement magnitude when negative, 255 extra on overflow
    function automatic int axis_move(input logic [BYTE_W-1:0] data, input logic neg,
                                     input logic ovf);
        logic [BYTE_W-1:0] twos;
        int                mag;
        twos = -data;
        mag  = neg ? int'(twos) : int'(data);
        if (ovf)
            mag += 255;
        return neg ? -mag : mag;
    endfunction

    // Clamp to [0, size-1]; a zero size behaves as one, the ceiling is 14 bits
    function automatic logic [POS_W-1:0] clamp_pos(input int p, input logic [SIZE_W-1:0] size);
        int lim;
        lim = (size == 0) ? 0 : int'(size) - 1;
        if (lim > int'(POS_MAX))
            lim = int'(POS_MAX);
        if (p < 0)
            p = 0;
        if (p > lim)
            p = lim;
        return POS_W'(p);
    endfunction

    always @(posedge i_clk) begin : track
        t_cursor want;
        int      nx;
        int      ny;
        if (!i_rst_n) begin
            width_q    = WIDTH_RST;
            height_q   = HEIGHT_RST;
            drop_first = 1'b1;
            pkt_phase  = PH_HDR;
            hdr_q      = '0;
            dx_q       = '0;
            cur_x      = '0;
            cur_y      = '0;
            cursor_q.delete();
        end else begin
            // Register writes land at the access beat
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_WIDTH)
                    width_q = pwdata[SIZE_W-1:0];
                else
                    height_q = pwdata[SIZE_W-1:0];
            end

            // Compare a result beat with the oldest prediction
            if (i_res_valid && i_res_ready) begin
                if (cursor_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result x=%0d y=%0d buttons=%b",
                                              i_cursor_x, i_cursor_y, i_buttons));
                end else begin
                    want = cursor_q.pop_front();
                    packet_count++;
                    if (i_cursor_x !== want.x)
                        report_mismatch($sformatf("cursor_x %0d, expected %0d",
                                                  i_cursor_x, want.x));
                    if (i_cursor_y !== want.y)
                        report_mismatch($sformatf("cursor_y %0d, expected %0d",
                                                  i_cursor_y, want.y));
                    if (i_buttons !== want.btn)
                        report_mismatch($sformatf("buttons %b, expected %b",
                                                  i_buttons, want.btn));
                end
            end

            // Advance the packet state on an accepted byte
            if (i_rx_valid && i_rx_ready) begin
                if (drop_first) begin
                    drop_first = 1'b0;
                end else if (pkt_phase == PH_DX) begin
                    dx_q      = i_rx_byte;
                    pkt_phase = PH_DY;
                end else if (pkt_phase != PH_DY) begin
                    pkt_phase = PH_HDR;
                    if (i_rx_byte[HDR_SYNC]) begin
                        hdr_q     = i_rx_byte;
                        pkt_phase = PH_DX;
                    end
                end else begin
                    pkt_phase = PH_HDR;
                    nx = int'(cur_x) + axis_move(dx_q, hdr_q[HDR_XSIGN], hdr_q[HDR_XOVF]);
                    ny = int'(cur_y) - axis_move(i_rx_byte, hdr_q[HDR_YSIGN], hdr_q[HDR_YOVF]);
                    cur_x = clamp_pos(nx, width_q);
                    cur_y = clamp_pos(ny, height_q);
                    want.x   = cur_x;
                    want.y   = cur_y;
                    want.btn = {hdr_q[HDR_RIGHT], hdr_q[HDR_MIDDLE], hdr_q[HDR_LEFT]};
                    cursor_q.push_back(want);
                end
            end
        end
        pending_count <= cursor_q.size();
    end

endmodule : ps2mt_checker

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the PS/2 mouse packet tracker. Sends a directed
// byte sequence, then random packets with noise under several screen sizes,
// with random gaps on the byte side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ps2mt_pkg::*;

    localparam int N_SIZES   = 8;
    localparam int SIZE_BEATS = 92;
    localparam int N_INTRO    = 21;

    logic               i_clk;
    logic               i_rst_n;
    logic               rx_valid;
    logic               rx_ready;
    logic [BYTE_W-1:0]  rx_byte;
    logic               res_valid;
    logic               res_ready;
    logic [POS_W-1:0]   cursor_x;
    logic [POS_W-1:0]   cursor_y;
    logic [BTN_W-1:0]   buttons;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int errors;
    int outstanding;
    int packets;
    int bytes_sent = 0;
    bit no_idle    = 1'b0;

    ps2_mouse_packet_tracker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (rx_valid),
        .o_rx_ready (rx_ready),
        .i_rx_byte  (rx_byte),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_cursor_x (cursor_x),
        .o_cursor_y (cursor_y),
        .o_buttons  (buttons),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    ps2mt_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (rx_valid),
        .i_rx_ready   (rx_ready),
        .i_rx_byte    (rx_byte),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_cursor_x   (cursor_x),
        .i_cursor_y   (cursor_y),
        .i_buttons    (buttons),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_errors     (errors),
        .o_outstanding(outstanding),
        .o_packets    (packets)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop for a hung run
    initial begin
        #5_000_000;
        $display("Timeout with %0d packets still expected", outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly short gaps, a few long ones, none in a burst stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Movement byte: mostly random, sometimes an edge value
    function automatic logic [BYTE_W-1:0] pick_delta();
        logic [BYTE_W-1:0] edges[5];
        edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(0, 4) == 0)
            return edges[$urandom_range(0, 4)];
        return BYTE_W'($urandom());
    endfunction

    // Result side: alternate ready stretches and stalls
    initial begin
        int run;
        res_ready = 1'b0;
        run       = 0;
        forever begin
            @(posedge i_clk);
            if (run > 0) begin
                run--;
            end else begin
                run = pick_gap();
                res_ready <= (run == 0);
                if (run == 0)
                    run = $urandom_range(0, 6);
            end
        end
    end

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge i_clk);
        while (!rx_ready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    // Register write: setup beat then access beat
    task automatic write_reg(input logic sel, input logic [SIZE_W-1:0] size);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {17'($urandom()), size};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid, drain the expected results, then let the pipeline empty
    task automatic settle();
        int guard;
        rx_valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (outstanding != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Random packets with per-run drift so the clamps on both edges are hit
    task automatic random_traffic(input int budget);
        int                sent;
        int                xdir;
        int                ydir;
        logic [BYTE_W-1:0] hdr;
        sent = 0;
        xdir = $urandom_range(0, 2);
        ydir = $urandom_range(0, 2);
        while (sent < budget) begin
            if ($urandom_range(0, 19) == 0)
                no_idle = ~no_idle;
            if ($urandom_range(0, 9) == 0) begin
                // noise byte: may resync or break the framing
                send_byte(BYTE_W'($urandom()));
                sent++;
            end else begin
                hdr = BYTE_W'($urandom());
                hdr[HDR_SYNC] = 1'b1;
                if (xdir != 0) begin
                    hdr[HDR_XSIGN] = (xdir == 2);
                    hdr[HDR_XOVF]  = ($urandom_range(0, 9) < 7);
                end
                if (ydir != 0) begin
                    hdr[HDR_YSIGN] = (ydir == 1);
                    hdr[HDR_YOVF]  = ($urandom_range(0, 9) < 7);
                end
                send_byte(hdr);
                send_byte(pick_delta());
                send_byte(pick_delta());
                sent += 3;
            end
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] intro[N_INTRO];
        logic [SIZE_W-1:0] widths[N_SIZES];
        logic [SIZE_W-1:0] heights[N_SIZES];
        rx_valid = 1'b0;
        rx_byte  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        i_rst_n  = 1'b0;

        // Drop a sync-looking first byte, skip non-sync headers, then walk the
        // header bits: buttons, signs, overflows, zero and full-scale deltas
        intro = '{8'h08, 8'h00, 8'hF7,
                  8'h09, 8'hFF, 8'h80,
                  8'h3E, 8'h00, 8'h01,
                  8'hC8, 8'hFF, 8'h00,
                  8'hF8, 8'h80, 8'hFF,
                  8'h0F, 8'h7F, 8'h7F,
                  8'hFF, 8'h00, 8'h80};

        // Smallest, nominal largest, zero, oversized and ordinary sizes
        widths  = '{15'd1, 15'd16384, 15'd0, 15'd32767, 15'd640, 15'd16383, 15'd300, 15'd0};
        heights = '{15'd1, 15'd16384, 15'd32767, 15'd0, 15'd480, 15'd2, 15'd200, 15'd0};
        widths[N_SIZES-1]  = SIZE_W'($urandom_range(2, 2000));
        heights[N_SIZES-1] = SIZE_W'($urandom_range(2, 2000));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (intro[k])
            send_byte(intro[k]);
        settle();

        for (int s = 0; s < N_SIZES; s++) begin
            write_reg(REG_WIDTH, widths[s]);
            write_reg(REG_HEIGHT, heights[s]);
            random_traffic(SIZE_BEATS);
            settle();
        end

        $display("Sent %0d bytes and checked %0d packets over the reset size and %0d written",
                 bytes_sent, packets, N_SIZES);
        $display("screen sizes, zero and oversized among them");
        if (outstanding != 0)
            $display("%0d expected packets never came out", outstanding);
        if (errors == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule : tb_top
